// ===== rtl/tbp_pkg.sv =====
// Shared constants and counter helpers for the tournament branch predictor.
package tbp_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int HISTORY_BITS = 12;
    localparam int TABLE_DEPTH  = 1 << INDEX_BITS;
    localparam int WIDE_BITS    = (INDEX_BITS > HISTORY_BITS) ? INDEX_BITS : HISTORY_BITS;

    localparam int PC_BITS       = 32;
    localparam int S_TDATA_BITS  = 40;
    localparam int M_TDATA_BITS  = 8;

    localparam logic [1:0] CTR_INIT = 2'b01;

    typedef logic [1:0]            ctr_t;
    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [HISTORY_BITS-1:0] hist_t;

    // Jump step: up 00->01, 01/10->11; down 11->10, 10/01->00.
    function automatic ctr_t ctr_move(input ctr_t c, input logic up);
        ctr_t r;
        if (up) begin
            r = (c == 2'b00) ? 2'b01 : 2'b11;
        end else begin
            r = (c == 2'b11) ? 2'b10 : 2'b00;
        end
        return r;
    endfunction

    function automatic logic ctr_taken(input ctr_t c);
        return c[1];
    endfunction

    // Fit the history to the index width: zero fill short histories, truncate long ones.
    function automatic idx_t hist_to_idx(input hist_t h);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(h);
        return w[INDEX_BITS-1:0];
    endfunction

endpackage

// ===== rtl/tournament_branch_predictor.sv =====
// Tournament branch predictor: bimodal and gshare counter tables with a global chooser.
//
// Usage: each slave beat carries one resolved branch (pc, actual direction).
// The master channel returns one beat per branch with the prediction that the
// predictor would have made before learning the outcome, both component
// guesses and a mispredict flag.
// Pipeline: an accepted input beat passes through the synchronous table read,
// then the update and output register, whose result beat shows on m_tvalid.
// Throughput: one branch per cycle unless the output stalls; the tables are read at acceptance and
// written back as the branch leaves the update stage, with a write-to-read forward covering a
// branch that hits the entry the previous branch just updated.
// Reset: aresetn (synchronous, active low) clears history and sets the chooser to 01, then a
// clearing pass writes 01 into all 4096 table entries, one entry per cycle;
// s_tready stays low during the pass.
// Stall: when m_tready is low with a result waiting, the in-flight branch and
// s_tready hold until the output register drains.
module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [31:0] pc, [32] taken, [39:33] zero
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] prediction, [1] bimodal_guess, [2] gshare_guess, [3] mispredicted, [7:4] zero
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    // Counter tables: synchronous read, one write port each.
    ctr_t bim_mem [TABLE_DEPTH];
    ctr_t gsh_mem [TABLE_DEPTH];

    // Clearing pass after reset.
    logic  clr_active_reg, clr_active_next;
    idx_t  clr_addr_reg,   clr_addr_next;

    // Global state.
    hist_t hist_reg,    hist_next;
    ctr_t  chooser_reg, chooser_next;

    // Update stage: the branch whose table data is being read out.
    logic  p1_valid_reg, p1_valid_next;
    logic  p1_taken_reg;
    idx_t  p1_bidx_reg;
    idx_t  p1_gidx_reg;
    ctr_t  bim_rd_reg;
    ctr_t  gsh_rd_reg;

    // Last write to each table, forwarded to a read of the same entry.
    logic  bfwd_valid_reg, fwd_valid_next;
    idx_t  bfwd_idx_reg;
    ctr_t  bfwd_val_reg;
    logic  gfwd_valid_reg;
    idx_t  gfwd_idx_reg;
    ctr_t  gfwd_val_reg;

    // Output register.
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg;

    logic  advance;
    logic  s_accept;
    logic  upd_en;
    logic  wr_en;
    idx_t  in_bidx, in_gidx;
    logic  in_taken;
    ctr_t  bim_cur, gsh_cur;
    ctr_t  bim_new, gsh_new;
    logic  bguess, gguess, pred;
    logic  bright, gright;
    idx_t  bwr_idx, gwr_idx;
    ctr_t  bwr_val, gwr_val;

    // Advance the update stage whenever the output register can take a beat.
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !clr_active_reg && advance;
    assign s_accept = s_tvalid && s_tready;
    assign upd_en   = p1_valid_reg && advance;
    assign wr_en    = clr_active_reg || upd_en;

    assign in_taken = s_tdata[PC_BITS];
    assign in_bidx  = s_tdata[INDEX_BITS-1:0];
    assign in_gidx  = s_tdata[INDEX_BITS-1:0] ^ hist_to_idx(hist_reg);

    always_comb begin
        bim_cur = (bfwd_valid_reg && (bfwd_idx_reg == p1_bidx_reg)) ? bfwd_val_reg : bim_rd_reg;
        gsh_cur = (gfwd_valid_reg && (gfwd_idx_reg == p1_gidx_reg)) ? gfwd_val_reg : gsh_rd_reg;
        bguess  = ctr_taken(bim_cur);
        gguess  = ctr_taken(gsh_cur);
        pred    = ctr_taken(chooser_reg) ? gguess : bguess;
        bright  = (bguess == p1_taken_reg);
        gright  = (gguess == p1_taken_reg);
        bim_new = ctr_move(bim_cur, p1_taken_reg);
        gsh_new = ctr_move(gsh_cur, p1_taken_reg);

        if (clr_active_reg) begin
            bwr_idx = clr_addr_reg;
            gwr_idx = clr_addr_reg;
            bwr_val = CTR_INIT;
            gwr_val = CTR_INIT;
        end else begin
            bwr_idx = p1_bidx_reg;
            gwr_idx = p1_gidx_reg;
            bwr_val = bim_new;
            gwr_val = gsh_new;
        end
    end

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + idx_t'(1);
            if (clr_addr_reg == {INDEX_BITS{1'b1}}) begin
                clr_active_next = 1'b0;
            end
        end

        // Shift the new outcome into history as soon as the branch enters.
        hist_next = s_accept ? HISTORY_BITS'({hist_reg, in_taken}) : hist_reg;

        // Move the chooser toward the component that alone was right.
        chooser_next = chooser_reg;
        if (upd_en) begin
            priority if (!bright && gright) begin
                chooser_next = ctr_move(chooser_reg, 1'b1);
            end else if (bright && !gright) begin
                chooser_next = ctr_move(chooser_reg, 1'b0);
            end else begin
                chooser_next = chooser_reg;
            end
        end

        p1_valid_next  = s_accept ? 1'b1 : (upd_en ? 1'b0 : p1_valid_reg);
        fwd_valid_next = bfwd_valid_reg || wr_en;

        priority if (upd_en) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            hist_reg       <= '0;
            chooser_reg    <= CTR_INIT;
            p1_valid_reg   <= 1'b0;
            bfwd_valid_reg <= 1'b0;
            gfwd_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            hist_reg       <= hist_next;
            chooser_reg    <= chooser_next;
            p1_valid_reg   <= p1_valid_next;
            bfwd_valid_reg <= fwd_valid_next;
            gfwd_valid_reg <= fwd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_taken_reg <= in_taken;
            p1_bidx_reg  <= in_bidx;
            p1_gidx_reg  <= in_gidx;
        end
        if (wr_en) begin
            bfwd_idx_reg <= bwr_idx;
            bfwd_val_reg <= bwr_val;
            gfwd_idx_reg <= gwr_idx;
            gfwd_val_reg <= gwr_val;
        end
        if (upd_en) begin
            m_tdata_reg <= M_TDATA_BITS'({(pred != p1_taken_reg), gguess, bguess, pred});
        end
    end

    // Bimodal table.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bim_rd_reg <= bim_mem[in_bidx];
        end
        if (wr_en) begin
            bim_mem[bwr_idx] <= bwr_val;
        end
    end

    // Gshare table.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            gsh_rd_reg <= gsh_mem[in_gidx];
        end
        if (wr_en) begin
            gsh_mem[gwr_idx] <= gwr_val;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // No branch enters while the tables are being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_tready)
        else $error("branch accepted during clearing pass");

    // An accepted branch occupies the update stage next cycle.
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> p1_valid_reg)
        else $error("accepted branch lost before update");

    // An update always produces a result beat.
    a_update_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |=> m_tvalid_reg)
        else $error("update produced no result beat");

    // The forward register tracks the entry just written back.
    a_fwd_tracks_write: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |=> (bfwd_idx_reg == $past(p1_bidx_reg)) && (gfwd_idx_reg == $past(p1_gidx_reg)))
        else $error("forward index does not match last write");

endmodule
